[rtl/queued_tone_generator_top_macros.svh]
// Assertion helpers for the queued tone generator.
// Both forms are disabled while reset is asserted (active low).
`ifndef QUEUED_TONE_GENERATOR_TOP_MACROS_SVH
`define QUEUED_TONE_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define QTG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone generator check failed");
// Next-cycle implication.
`define QTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone generator check failed");
`else
`define QTG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define QTG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/qtg_pkg.sv]
`timescale 1ns / 1ps

package qtg_pkg;

    // Sizing
    localparam int QUEUE_DEPTH  = 16;
    localparam int SINE_ENTRIES = 1024;
    localparam int SAMPLE_RATE  = 44100;

    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SINE_W   = $clog2(SINE_ENTRIES);

    // Field widths
    localparam int FREQ_W   = 19;
    localparam int MS_W     = 16;
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 5;
    localparam int AMP_W    = 15;
    localparam int MAG_W    = 15;
    localparam int STEP_W   = 32;
    localparam int COUNT_W  = 22;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [AMP_W-1:0]   AMP_RESET = AMP_W'(28000);

    // Output scaling: amplitude * magnitude / 32768, rounded half up
    localparam int SCALE_SH = 15;
    localparam logic [AMP_W+MAG_W:0] ROUND_HALF = (AMP_W+MAG_W+1)'(1) << (SCALE_SH - 1);

    // Phase step = freq * 2^32 / (16 * rate) = freq * STEP_A + freq * STEP_B / STEP_DIV
    localparam int STEP_DIV = 16 * SAMPLE_RATE;
    localparam int DIV_W    = $clog2(STEP_DIV + 1);
    localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;
    localparam logic [STEP_W-1:0] STEP_A = STEP_W'(TWO_POW_32 / 64'(STEP_DIV));
    localparam logic [DIV_W-1:0]  STEP_B = DIV_W'(TWO_POW_32 % 64'(STEP_DIV));
    localparam logic [STEP_W-1:0] STEP_C = STEP_W'((64'(STEP_B) << 32) / 64'(STEP_DIV));

    // Sample count = ms * rate / 1000 = ms * CNT_A + ms * CNT_B / 1000
    localparam int MS_PER_S = 1000;
    localparam int CNT_A    = SAMPLE_RATE / MS_PER_S;
    localparam int CNT_B    = SAMPLE_RATE % MS_PER_S;
    localparam int CNTA_W   = $clog2(CNT_A + 1);
    localparam int CNTB_W   = $clog2(MS_PER_S);
    localparam logic [STEP_W-1:0] CNT_C = STEP_W'((64'(CNT_B) << 32) / 64'(MS_PER_S));

    // Sine table construction in Q30
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] MAG_FULL    = 64'd32767;

    // Command codes from front to back
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_PUSH = 2'd1;
    localparam logic [1:0] CMD_DROP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 1'd1;

    // Command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         kind;
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    // Advance a beep queue slot, wrapping at the queue depth
    function automatic logic [SLOT_W-1:0] f_slot_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    // Magnitude of table entry k: round(32767 * |sin(2*pi*k/N)|)
    function automatic logic [MAG_W-1:0] f_sine_mag(input int unsigned k);
        logic [63:0] t;
        logic [63:0] quad;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] qs;
        logic [63:0] m;
        logic signed [65:0] sum;
        t    = (64'(k) << 32) / SINE_ENTRIES;
        quad = (t >> 30) & 64'd3;
        f    = t & (Q30_ONE - 64'd1);
        if (quad[0]) begin
            f = Q30_ONE - f;
        end
        x    = (f * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({2'b00, x});
        term = ((term * x2) >> 30) / 6;
        sum  = sum - $signed({2'b00, term});
        term = ((term * x2) >> 30) / 20;
        sum  = sum + $signed({2'b00, term});
        term = ((term * x2) >> 30) / 42;
        sum  = sum - $signed({2'b00, term});
        term = ((term * x2) >> 30) / 72;
        sum  = sum + $signed({2'b00, term});
        term = ((term * x2) >> 30) / 110;
        sum  = sum - $signed({2'b00, term});
        qs   = (sum < 0) ? 64'd0 : sum[63:0];
        m    = (qs * MAG_FULL + (64'd1 << 29)) >> 30;
        if (m > MAG_FULL) begin
            m = MAG_FULL;
        end
        return MAG_W'(m);
    endfunction

endpackage

[rtl/qtg_in_if.sv]
`timescale 1ns / 1ps

interface qtg_in_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [qtg_pkg::FREQ_W-1:0]    beep_freq;
    logic [qtg_pkg::MS_W-1:0]      beep_ms;

    modport source (output valid, output req_type, output beep_freq, output beep_ms,
                    input ready);
    modport sink   (input valid, input req_type, input beep_freq, input beep_ms,
                    output ready);
endinterface

[rtl/qtg_out_if.sv]
`timescale 1ns / 1ps

interface qtg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [qtg_pkg::SAMPLE_W-1:0] sample;
    logic                                accepted;
    logic [qtg_pkg::LEVEL_W-1:0]         queue_level;
    logic                                playing;

    modport source (output valid, output sample, output accepted, output queue_level,
                    output playing, input ready);
    modport sink   (input valid, input sample, input accepted, input queue_level,
                    input playing, output ready);
endinterface

[rtl/qtg_cfg_if.sv]
`timescale 1ns / 1ps

interface qtg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qtg_pkg::CFG_IDX_W-1:0]     index;
    logic [qtg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/queued_tone_generator_top.sv]
`timescale 1ns / 1ps

// Queued sine tone generator. Push items queue beeps (up to 16); each tick
// item returns one signed sample of the beep at the head of the queue, and
// every item returns exactly one result. The block takes one item per clock
// cycle when the output is drained each cycle; a result reaches the output
// through seven register stages, the first loaded by the input transfer
// itself: three conversion stages, the command queue, then execute, multiply
// and output stages. The sustained rate is set by the execute stage, which
// updates the beep queue, sample count and phase accumulator once per cycle.
// A stalled output first fills a four-entry command queue before the input
// stops taking items. Configuration writes are always taken and must only
// happen while the block is idle.
`include "queued_tone_generator_top_macros.svh"

module queued_tone_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qtg_in_if.sink      i_in,
    qtg_out_if.source   o_out,
    qtg_cfg_if.sink     i_cfg
);

    logic                          r_sound_enable;
    logic [qtg_pkg::AMP_W-1:0]     r_amplitude;

    qtg_pkg::t_cmd                 w_front_cmd;
    qtg_pkg::t_cmd                 w_back_cmd;
    logic                          w_cmd_push;
    logic                          w_cmd_ready;
    logic                          w_cmd_pop;
    logic                          w_cmd_valid;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_enable <= 1'b1;
            r_amplitude    <= qtg_pkg::AMP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                qtg_pkg::CFG_SOUND_ENABLE: begin
                    r_sound_enable <= i_cfg.data[0];
                end
                qtg_pkg::CFG_AMPLITUDE: begin
                    r_amplitude <= i_cfg.data[qtg_pkg::AMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    qtg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sound_enable (r_sound_enable),
        .i_in           (i_in),
        .o_cmd          (w_front_cmd),
        .o_cmd_push     (w_cmd_push),
        .i_cmd_ready    (w_cmd_ready)
    );

    qtg_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_front_cmd),
        .o_ready (w_cmd_ready),
        .i_pop   (w_cmd_pop),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_back_cmd)
    );

    qtg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_amplitude (r_amplitude),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_back_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out       (o_out)
    );

    // Input only stalls behind a full command queue
    `QTG_ASSERT_IMPLY(a_stall_on_full, i_clk, i_rst_n, !i_in.ready, !w_cmd_ready)
    // A full queue that is not drained stays full
    `QTG_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, !w_cmd_ready && !w_cmd_pop, !w_cmd_ready)
    // A stored push never carries a tone sample
    `QTG_ASSERT_IMPLY(a_push_silent, i_clk, i_rst_n, o_out.valid && o_out.accepted, !o_out.playing && (o_out.sample == '0))
    // Silence whenever no tone is playing
    `QTG_ASSERT_IMPLY(a_idle_zero, i_clk, i_rst_n, o_out.valid && !o_out.playing, o_out.sample == '0)

endmodule

[rtl/qtg_front.sv]
`timescale 1ns / 1ps

// Front end: takes items, turns a push into phase step and sample count,
// and classifies each item into a command for the back end.
module qtg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sound_enable,
    qtg_in_if.sink              i_in,
    output qtg_pkg::t_cmd       o_cmd,
    output logic                o_cmd_push,
    input  logic                i_cmd_ready
);

    localparam int PF_W  = qtg_pkg::FREQ_W + qtg_pkg::STEP_W;
    localparam int LF_W  = qtg_pkg::FREQ_W + qtg_pkg::DIV_W;
    localparam int PM_W  = qtg_pkg::MS_W + qtg_pkg::STEP_W;
    localparam int AM_W  = qtg_pkg::MS_W + qtg_pkg::CNTA_W;
    localparam int LM_W  = qtg_pkg::MS_W + qtg_pkg::CNTB_W;
    localparam int SUM_W = AM_W + 1;

    logic w_en;

    // Stage 1 products
    logic [PF_W-1:0] w_pc_f;
    logic [PF_W-1:0] w_pa_f;
    logic [LF_W-1:0] w_lo_f;
    logic [PM_W-1:0] w_pc_ms;
    logic [AM_W-1:0] w_a_ms;
    logic [LM_W-1:0] w_lo_ms;

    logic                          r_f1_v;
    logic                          r_f1_tick;
    logic [qtg_pkg::FREQ_W-1:0]    r_f1_est_f;
    logic [qtg_pkg::STEP_W-1:0]    r_f1_hi;
    logic [LF_W-1:0]               r_f1_lo_f;
    logic [qtg_pkg::MS_W-1:0]      r_f1_est_ms;
    logic [AM_W-1:0]               r_f1_a_ms;
    logic [LM_W-1:0]               r_f1_lo_ms;

    logic                          r_f2_v;
    logic                          r_f2_tick;
    logic [qtg_pkg::FREQ_W-1:0]    r_f2_est_f;
    logic [qtg_pkg::STEP_W-1:0]    r_f2_hi;
    logic [LF_W-1:0]               r_f2_lo_f;
    logic [LF_W-1:0]               r_f2_estd_f;
    logic [qtg_pkg::MS_W-1:0]      r_f2_est_ms;
    logic [AM_W-1:0]               r_f2_a_ms;
    logic [LM_W-1:0]               r_f2_lo_ms;
    logic [LM_W-1:0]               r_f2_estd_ms;

    logic [LF_W-1:0]               w_rem_f;
    logic [LM_W-1:0]               w_rem_ms;

    logic                          r_f3_v;
    logic                          r_f3_tick;
    logic [qtg_pkg::STEP_W-1:0]    r_f3_hi;
    logic [qtg_pkg::FREQ_W-1:0]    r_f3_q_f;
    logic [AM_W-1:0]               r_f3_a_ms;
    logic [qtg_pkg::MS_W-1:0]      r_f3_q_ms;

    logic [SUM_W-1:0]              w_cnt_sum;
    logic [qtg_pkg::COUNT_W-1:0]   w_count;

    // Whole front advances unless a finished command waits on a full queue
    assign w_en       = !r_f3_v || i_cmd_ready;
    assign i_in.ready = w_en;

    // Reciprocal estimates and constant products
    assign w_pc_f  = PF_W'(i_in.beep_freq) * PF_W'(qtg_pkg::STEP_C);
    assign w_pa_f  = PF_W'(i_in.beep_freq) * PF_W'(qtg_pkg::STEP_A);
    assign w_lo_f  = LF_W'(i_in.beep_freq) * LF_W'(qtg_pkg::STEP_B);
    assign w_pc_ms = PM_W'(i_in.beep_ms) * PM_W'(qtg_pkg::CNT_C);
    assign w_a_ms  = AM_W'(i_in.beep_ms) * AM_W'(qtg_pkg::CNT_A);
    assign w_lo_ms = LM_W'(i_in.beep_ms) * LM_W'(qtg_pkg::CNT_B);

    // Remainders after the estimate; at most one correction needed
    assign w_rem_f  = r_f2_lo_f - r_f2_estd_f;
    assign w_rem_ms = r_f2_lo_ms - r_f2_estd_ms;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= i_in.valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_tick   <= i_in.req_type;
            r_f1_est_f  <= w_pc_f[PF_W-1 -: qtg_pkg::FREQ_W];
            r_f1_hi     <= w_pa_f[qtg_pkg::STEP_W-1:0];
            r_f1_lo_f   <= w_lo_f;
            r_f1_est_ms <= w_pc_ms[PM_W-1 -: qtg_pkg::MS_W];
            r_f1_a_ms   <= w_a_ms;
            r_f1_lo_ms  <= w_lo_ms;

            r_f2_tick    <= r_f1_tick;
            r_f2_est_f   <= r_f1_est_f;
            r_f2_hi      <= r_f1_hi;
            r_f2_lo_f    <= r_f1_lo_f;
            r_f2_estd_f  <= LF_W'(r_f1_est_f) * LF_W'(qtg_pkg::STEP_DIV);
            r_f2_est_ms  <= r_f1_est_ms;
            r_f2_a_ms    <= r_f1_a_ms;
            r_f2_lo_ms   <= r_f1_lo_ms;
            r_f2_estd_ms <= LM_W'(r_f1_est_ms) * LM_W'(qtg_pkg::MS_PER_S);

            r_f3_tick <= r_f2_tick;
            r_f3_hi   <= r_f2_hi;
            r_f3_q_f  <= r_f2_est_f
                       + qtg_pkg::FREQ_W'(w_rem_f >= LF_W'(qtg_pkg::STEP_DIV));
            r_f3_a_ms <= r_f2_a_ms;
            r_f3_q_ms <= r_f2_est_ms
                       + qtg_pkg::MS_W'(w_rem_ms >= LM_W'(qtg_pkg::MS_PER_S));
        end
    end

    // Combine, saturate the count and classify
    assign w_cnt_sum = SUM_W'(r_f3_a_ms) + SUM_W'(r_f3_q_ms);
    assign w_count   = (w_cnt_sum > SUM_W'(qtg_pkg::COUNT_MAX)) ? qtg_pkg::COUNT_MAX
                                                                 : w_cnt_sum[qtg_pkg::COUNT_W-1:0];

    always_comb begin
        o_cmd.step  = r_f3_hi + qtg_pkg::STEP_W'(r_f3_q_f);
        o_cmd.count = w_count;
        if (r_f3_tick) begin
            o_cmd.kind = qtg_pkg::CMD_TICK;
        end else if (i_sound_enable && (w_count != '0)) begin
            o_cmd.kind = qtg_pkg::CMD_PUSH;
        end else begin
            o_cmd.kind = qtg_pkg::CMD_DROP;
        end
    end

    assign o_cmd_push = r_f3_v && i_cmd_ready;

endmodule

[rtl/qtg_cmd_fifo.sv]
`timescale 1ns / 1ps

// Short command queue between front and back.
module qtg_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qtg_pkg::t_cmd   i_cmd,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output qtg_pkg::t_cmd   o_cmd
);

    qtg_pkg::t_cmd                   r_mem [qtg_pkg::CMD_DEPTH];
    logic [qtg_pkg::CMD_PTR_W-1:0]   r_wr;
    logic [qtg_pkg::CMD_PTR_W-1:0]   r_rd;
    logic [qtg_pkg::CMD_CNT_W-1:0]   r_cnt;
    logic [qtg_pkg::CMD_CNT_W-1:0]   n_cnt;

    assign o_ready = (r_cnt != qtg_pkg::CMD_CNT_W'(qtg_pkg::CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    // Occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + qtg_pkg::CMD_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - qtg_pkg::CMD_CNT_W'(1);
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + qtg_pkg::CMD_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + qtg_pkg::CMD_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[rtl/qtg_back.sv]
`timescale 1ns / 1ps

// Back end: runs commands against the beep queue and phase accumulator,
// then looks up, scales and signs the sine sample.
module qtg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [qtg_pkg::AMP_W-1:0]     i_amplitude,
    input  logic                          i_cmd_valid,
    input  qtg_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    qtg_out_if.source                     o_out
);

    localparam int PROD_W = qtg_pkg::AMP_W + qtg_pkg::MAG_W;

    // Beep queue and tone state
    logic [qtg_pkg::STEP_W-1:0]   r_step  [qtg_pkg::QUEUE_DEPTH];
    logic [qtg_pkg::COUNT_W-1:0]  r_count [qtg_pkg::QUEUE_DEPTH];
    logic [qtg_pkg::SLOT_W-1:0]   r_rd;
    logic [qtg_pkg::SLOT_W-1:0]   r_wr;
    logic [qtg_pkg::FILL_W-1:0]   r_fill;
    logic [qtg_pkg::STEP_W-1:0]   r_phase;
    logic [qtg_pkg::SLOT_W-1:0]   n_rd;
    logic [qtg_pkg::SLOT_W-1:0]   n_wr;
    logic [qtg_pkg::FILL_W-1:0]   n_fill;
    logic [qtg_pkg::STEP_W-1:0]   n_phase;

    logic [qtg_pkg::MAG_W-1:0]    w_sine [qtg_pkg::SINE_ENTRIES];

    logic                         w_en;
    logic                         w_store;
    logic                         w_play;
    logic [qtg_pkg::COUNT_W-1:0]  w_head_cnt;
    logic                         w_last;

    // Execute stage results
    logic                         r_e_v;
    logic                         r_e_play;
    logic                         r_e_acc;
    logic [qtg_pkg::LEVEL_W-1:0]  r_e_level;
    logic                         r_e_sign;
    logic [qtg_pkg::MAG_W-1:0]    r_e_mag;

    // Multiply stage
    logic                         r_m_v;
    logic                         r_m_play;
    logic                         r_m_acc;
    logic [qtg_pkg::LEVEL_W-1:0]  r_m_level;
    logic                         r_m_sign;
    logic [PROD_W-1:0]            r_m_prod;

    // Output register
    logic                          r_o_v;
    logic signed [qtg_pkg::SAMPLE_W-1:0] r_o_sample;
    logic                          r_o_acc;
    logic [qtg_pkg::LEVEL_W-1:0]   r_o_level;
    logic                          r_o_play;

    logic [PROD_W:0]                w_round;
    logic [qtg_pkg::SAMPLE_W-1:0]   w_mag_out;
    logic [qtg_pkg::SAMPLE_W-1:0]   w_sample;

    // Constant sine magnitude table
    for (genvar k = 0; k < qtg_pkg::SINE_ENTRIES; k++) begin : g_sine
        assign w_sine[k] = qtg_pkg::f_sine_mag(k);
    end

    // Whole back pipeline moves when the output register is free or taken
    assign w_en      = !r_o_v || o_out.ready;
    assign o_cmd_pop = i_cmd_valid && w_en;

    assign w_store    = o_cmd_pop && (i_cmd.kind == qtg_pkg::CMD_PUSH)
                      && (r_fill != qtg_pkg::FILL_W'(qtg_pkg::QUEUE_DEPTH));
    assign w_play     = o_cmd_pop && (i_cmd.kind == qtg_pkg::CMD_TICK) && (r_fill != '0);
    assign w_head_cnt = r_count[r_rd];
    assign w_last     = (w_head_cnt <= qtg_pkg::COUNT_W'(1));

    // Queue and phase update
    always_comb begin
        n_rd    = r_rd;
        n_wr    = r_wr;
        n_fill  = r_fill;
        n_phase = r_phase;
        if (w_store) begin
            n_wr   = qtg_pkg::f_slot_next(r_wr);
            n_fill = r_fill + qtg_pkg::FILL_W'(1);
        end
        if (w_play) begin
            n_phase = r_phase + r_step[r_rd];
            if (w_last) begin
                n_rd   = qtg_pkg::f_slot_next(r_rd);
                n_fill = r_fill - qtg_pkg::FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_fill  <= '0;
            r_phase <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_fill  <= n_fill;
            r_phase <= n_phase;
        end
    end

    // Store a beep, or count down the one playing
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_step[r_wr]  <= i_cmd.step;
            r_count[r_wr] <= i_cmd.count;
        end else if (w_play && !w_last) begin
            r_count[r_rd] <= w_head_cnt - qtg_pkg::COUNT_W'(1);
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= o_cmd_pop;
            r_m_v <= r_e_v;
            r_o_v <= r_m_v;
        end
    end

    // Rounding and sign
    assign w_round   = (PROD_W+1)'(r_m_prod) + qtg_pkg::ROUND_HALF;
    assign w_mag_out = qtg_pkg::SAMPLE_W'(w_round >> qtg_pkg::SCALE_SH);

    always_comb begin
        if (!r_m_play) begin
            w_sample = '0;
        end else if (r_m_sign) begin
            w_sample = '0 - w_mag_out;
        end else begin
            w_sample = w_mag_out;
        end
    end

    // Table read, multiply, output
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_play  <= w_play;
            r_e_acc   <= w_store;
            r_e_level <= qtg_pkg::LEVEL_W'(n_fill);
            r_e_sign  <= r_phase[qtg_pkg::STEP_W-1];
            r_e_mag   <= w_sine[r_phase[qtg_pkg::STEP_W-1 -: qtg_pkg::SINE_W]];

            r_m_play  <= r_e_play;
            r_m_acc   <= r_e_acc;
            r_m_level <= r_e_level;
            r_m_sign  <= r_e_sign;
            r_m_prod  <= PROD_W'(i_amplitude) * PROD_W'(r_e_mag);

            r_o_play   <= r_m_play;
            r_o_acc    <= r_m_acc;
            r_o_level  <= r_m_level;
            r_o_sample <= $signed(w_sample);
        end
    end

    assign o_out.valid       = r_o_v;
    assign o_out.sample      = r_o_sample;
    assign o_out.accepted    = r_o_acc;
    assign o_out.queue_level = r_o_level;
    assign o_out.playing     = r_o_play;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_TICK = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind                  req_type;
        logic [qtg_pkg::FREQ_W-1:0] freq;
        logic [qtg_pkg::MS_W-1:0]   ms;
    } t_beep_item;

    typedef struct packed {
        logic [qtg_pkg::SAMPLE_W-1:0] sample;
        logic                         accepted;
        logic [qtg_pkg::LEVEL_W-1:0]  level;
        logic                         playing;
    } t_tone_result;

    localparam logic [63:0] HALF_PI_FX  = 64'd1686629713;
    localparam logic [63:0] FX_ONE      = 64'd1 << 30;
    localparam logic [63:0] PEAK_MAG    = 64'd32767;
    localparam int          HOLD_AT     = 200;
    localparam int          HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    qtg_in_if  in_if ();
    qtg_out_if out_if ();
    qtg_cfg_if cfg_if ();

    queued_tone_generator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Stimulus and expectation stores
    t_beep_item   pending_beeps[$];
    t_tone_result tone_results_due[$];

    // Predicted block state
    int                          sine_lut[qtg_pkg::SINE_ENTRIES];
    logic [qtg_pkg::STEP_W-1:0]  step_mem[qtg_pkg::QUEUE_DEPTH];
    logic [qtg_pkg::COUNT_W-1:0] count_mem[qtg_pkg::QUEUE_DEPTH];
    int unsigned                 rd_slot;
    int unsigned                 wr_slot;
    int unsigned                 beep_fill;
    logic [31:0]                 phase_sum;
    logic                        snd_on;
    logic [qtg_pkg::AMP_W-1:0]   snd_amp;

    // Handshake flags seen at the last rising edge
    logic in_xfer  = 1'b0;
    logic cfg_xfer = 1'b0;

    int  results_seen = 0;
    int  mismatches   = 0;
    bit  calm         = 1'b0;
    int  hold_left    = 0;
    bit  held_off     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Signed table entry k: round(32767 * sin(2*pi*k/N)) via a Q30 Taylor series
    function automatic int calc_sine_entry(input int unsigned k);
        logic [63:0] t;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] qs;
        logic [63:0] m;
        logic [1:0]  quad;
        longint      acc;
        int unsigned n;
        t    = ({32'd0, k} << 32) / 64'(qtg_pkg::SINE_ENTRIES);
        quad = t[31:30];
        f    = t & (FX_ONE - 64'd1);
        if (quad[0]) begin
            f = FX_ONE - f;
        end
        x    = (f * HALF_PI_FX) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
            if (n[0]) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        qs = (acc < 0) ? 64'd0 : 64'(acc);
        m  = (qs * PEAK_MAG + (64'd1 << 29)) >> 30;
        if (m > PEAK_MAG) begin
            m = PEAK_MAG;
        end
        return quad[1] ? -int'(m) : int'(m);
    endfunction

    // Work out the result of one item and advance the predicted state
    function automatic t_tone_result predict_tone(input t_beep_item it);
        t_tone_result res;
        logic [63:0]  n_samples;
        logic [63:0]  phase_inc;
        int           e;
        logic [31:0]  mag;
        logic [31:0]  scaled;
        res = '0;
        if (it.req_type == REQ_PUSH) begin
            n_samples = 64'(it.ms) * 64'(qtg_pkg::SAMPLE_RATE) / 64'd1000;
            phase_inc = (64'(it.freq) << 32) / (64'd16 * 64'(qtg_pkg::SAMPLE_RATE));
            if (n_samples > 64'(qtg_pkg::COUNT_MAX)) begin
                n_samples = 64'(qtg_pkg::COUNT_MAX);
            end
            if (snd_on && beep_fill < qtg_pkg::QUEUE_DEPTH && n_samples != 64'd0) begin
                step_mem[wr_slot]  = phase_inc[qtg_pkg::STEP_W-1:0];
                count_mem[wr_slot] = n_samples[qtg_pkg::COUNT_W-1:0];
                wr_slot            = (wr_slot + 1) % qtg_pkg::QUEUE_DEPTH;
                beep_fill          = beep_fill + 1;
                res.accepted       = 1'b1;
            end
        end else if (beep_fill != 0) begin
            e           = sine_lut[phase_sum[31 -: qtg_pkg::SINE_W]];
            mag         = (e < 0) ? 32'(-e) : 32'(e);
            scaled      = (32'(snd_amp) * mag + 32'd16384) >> 15;
            res.sample  = (e < 0) ? qtg_pkg::SAMPLE_W'(~scaled + 32'd1)
                                  : qtg_pkg::SAMPLE_W'(scaled);
            res.playing = 1'b1;
            phase_sum   = phase_sum + step_mem[rd_slot];
            if (count_mem[rd_slot] > 1) begin
                count_mem[rd_slot] = count_mem[rd_slot] - 1'b1;
            end else begin
                count_mem[rd_slot] = '0;
                rd_slot            = (rd_slot + 1) % qtg_pkg::QUEUE_DEPTH;
                beep_fill          = beep_fill - 1;
            end
        end
        res.level = qtg_pkg::LEVEL_W'(beep_fill);
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Track transfers, predict accepted items and check each result transfer
    always @(posedge i_clk) begin : result_check
        t_tone_result want;
        t_beep_item   got;
        if (!i_rst_n) begin
            in_xfer   <= 1'b0;
            cfg_xfer  <= 1'b0;
            snd_on    = 1'b1;
            snd_amp   = qtg_pkg::AMP_RESET;
            rd_slot   = 0;
            wr_slot   = 0;
            beep_fill = 0;
            phase_sum = '0;
        end else begin
            in_xfer  <= in_if.valid && in_if.ready;
            cfg_xfer <= cfg_if.valid && cfg_if.ready;
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    qtg_pkg::CFG_SOUND_ENABLE: snd_on  = cfg_if.data[0];
                    qtg_pkg::CFG_AMPLITUDE:    snd_amp = cfg_if.data[qtg_pkg::AMP_W-1:0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                got.req_type = t_req_kind'(in_if.req_type);
                got.freq     = in_if.beep_freq;
                got.ms       = in_if.beep_ms;
                tone_results_due.push_back(predict_tone(got));
            end
            if (out_if.valid && out_if.ready) begin
                results_seen <= results_seen + 1;
                if (tone_results_due.size() == 0) begin
                    log_mismatch("result transfer with nothing due");
                end else begin
                    want = tone_results_due.pop_front();
                    if (out_if.sample !== want.sample) begin
                        log_mismatch($sformatf("sample got %0d want %0d",
                                     $signed(out_if.sample), $signed(want.sample)));
                    end
                    if (out_if.accepted !== want.accepted) begin
                        log_mismatch($sformatf("accepted got %b want %b",
                                     out_if.accepted, want.accepted));
                    end
                    if (out_if.queue_level !== want.level) begin
                        log_mismatch($sformatf("queue_level got %0d want %0d",
                                     out_if.queue_level, want.level));
                    end
                    if (out_if.playing !== want.playing) begin
                        log_mismatch($sformatf("playing got %b want %b",
                                     out_if.playing, want.playing));
                    end
                end
            end
        end
    end

    // Offer pending items, idling now and then unless calm
    always @(negedge i_clk) begin : beep_driver
        t_beep_item it;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_xfer) begin
            if (pending_beeps.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
                it                = pending_beeps.pop_front();
                in_if.valid     <= 1'b1;
                in_if.req_type  <= it.req_type;
                in_if.beep_freq <= it.freq;
                in_if.beep_ms   <= it.ms;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Accept results; hold off once for a long stretch to back the block up
    always @(negedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (!held_off && results_seen >= HOLD_AT) begin
            held_off     <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    task automatic add_beep(input t_req_kind kind, input logic [qtg_pkg::FREQ_W-1:0] freq,
                            input logic [qtg_pkg::MS_W-1:0] ms);
        t_beep_item it;
        it.req_type = kind;
        it.freq     = freq;
        it.ms       = ms;
        pending_beeps.push_back(it);
    endtask

    // Queue random items; pushes mostly carry short beeps so the queue keeps moving
    task automatic queue_random_beeps(input int n, input int push_pct, input bit wide_ms);
        t_beep_item it;
        int         r;
        repeat (n) begin
            it.req_type = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_TICK;
            r = $urandom_range(99);
            if (r < 50) begin
                it.freq = qtg_pkg::FREQ_W'($urandom);
            end else if (r < 90) begin
                it.freq = qtg_pkg::FREQ_W'($urandom_range(0, 352800));
            end else begin
                case ($urandom_range(2))
                    0:       it.freq = '0;
                    1:       it.freq = qtg_pkg::FREQ_W'(352800);
                    default: it.freq = '1;
                endcase
            end
            r = $urandom_range(99);
            if (it.req_type == REQ_TICK || (wide_ms && r < 30)) begin
                it.ms = qtg_pkg::MS_W'($urandom);
            end else if (r < 36) begin
                it.ms = '0;
            end else if (r < 88) begin
                it.ms = qtg_pkg::MS_W'(1);
            end else begin
                it.ms = qtg_pkg::MS_W'($urandom_range(2, 3));
            end
            pending_beeps.push_back(it);
        end
    endtask

    task automatic write_reg(input logic [qtg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qtg_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(negedge i_clk); while (!cfg_xfer);
        cfg_if.valid <= 1'b0;
    endtask

    // Upper data bits are don't-care for the enable
    task automatic set_sound(input bit en);
        write_reg(qtg_pkg::CFG_SOUND_ENABLE, qtg_pkg::CFG_DATA_W'({$urandom, en}));
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_drained;
        do @(posedge i_clk);
        while (pending_beeps.size() != 0 || in_if.valid || tone_results_due.size() != 0);
    endtask

    initial begin : stimulus
        int i;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.req_type   = 1'b0;
        in_if.beep_freq  = '0;
        in_if.beep_ms    = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        for (i = 0; i < qtg_pkg::SINE_ENTRIES; i++) begin
            sine_lut[i] = calc_sine_entry(i);
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty tick, zero-length push, fastest tone, then fill and overflow the queue
        add_beep(REQ_TICK, '1, '1);
        add_beep(REQ_PUSH, '0, '0);
        add_beep(REQ_PUSH, '1, qtg_pkg::MS_W'(1));
        add_beep(REQ_TICK, '0, '0);
        add_beep(REQ_TICK, qtg_pkg::FREQ_W'(19'h2AAAA), qtg_pkg::MS_W'(16'h5555));
        for (i = 0; i < qtg_pkg::QUEUE_DEPTH - 1; i++) begin
            add_beep(REQ_PUSH,
                     (i == 0) ? qtg_pkg::FREQ_W'(352800) :
                     (i == 1) ? qtg_pkg::FREQ_W'(1) :
                                qtg_pkg::FREQ_W'($urandom_range(16, 352800)),
                     (i < 3) ? qtg_pkg::MS_W'(2) : qtg_pkg::MS_W'(1));
        end
        add_beep(REQ_PUSH, qtg_pkg::FREQ_W'(352800), '1);
        add_beep(REQ_TICK, qtg_pkg::FREQ_W'(19'h55555), qtg_pkg::MS_W'(16'hAAAA));
        wait_drained;

        // Sound off at full amplitude: pushes dropped, ticks still play
        set_sound(1'b0);
        write_reg(qtg_pkg::CFG_AMPLITUDE, '1);
        add_beep(REQ_PUSH, '1, '1);
        add_beep(REQ_TICK, '0, '0);
        add_beep(REQ_PUSH, qtg_pkg::FREQ_W'(1000), qtg_pkg::MS_W'(1));
        add_beep(REQ_TICK, '1, '1);
        wait_drained;

        // Random phases, each under its own settings
        set_sound(1'b1);
        write_reg(qtg_pkg::CFG_AMPLITUDE, qtg_pkg::CFG_DATA_W'($urandom_range(1, 32766)));
        queue_random_beeps(100, 6, 1'b0);
        wait_drained;

        write_reg(qtg_pkg::CFG_AMPLITUDE, '0);
        queue_random_beeps(100, 6, 1'b0);
        wait_drained;

        calm = 1'b1;
        write_reg(qtg_pkg::CFG_AMPLITUDE, '1);
        queue_random_beeps(100, 25, 1'b0);
        wait_drained;
        calm = 1'b0;

        set_sound(1'b0);
        write_reg(qtg_pkg::CFG_AMPLITUDE, qtg_pkg::CFG_DATA_W'(1));
        queue_random_beeps(100, 25, 1'b1);
        wait_drained;

        set_sound(1'b1);
        write_reg(qtg_pkg::CFG_AMPLITUDE, qtg_pkg::CFG_DATA_W'(28000));
        queue_random_beeps(100, 6, 1'b0);
        wait_drained;

        write_reg(qtg_pkg::CFG_AMPLITUDE, qtg_pkg::CFG_DATA_W'($urandom));
        queue_random_beeps(100, 12, 1'b1);
        wait_drained;

        // Let any stray result show up before the verdict
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
